// ===== sv/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled while in reset
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/lru_pkg.sv =====
// package with shared types and codes of the lru age counter block
`default_nettype none

package lru_pkg;

   // request type codes
   localparam logic [1:0] REQ_HIT    = 2'd0;
   localparam logic [1:0] REQ_FILL   = 2'd1;
   localparam logic [1:0] REQ_VICTIM = 2'd2;

   // configuration register indexes
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 7;
   localparam logic [CSR_INDEX_W-1:0] CSR_ASSOC_MODE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SET_WAYS   = 2'd1;

   // configuration reset values
   localparam logic       ASSOC_MODE_RESET = 1'b1;
   localparam logic [6:0] SET_WAYS_RESET   = 7'd4;

   // request transaction payload
   typedef struct packed {
      logic [1:0] req_type;
      logic [5:0] line_index;
      logic [5:0] set_index;
      logic       line_valid;
   } lru_req_type;

   // response transaction payload
   typedef struct packed {
      logic [5:0] victim_line;
      logic       done_res;
   } lru_rsp_type;

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BOUNDS,
      ST_REF,
      ST_WALK,
      ST_DRAIN,
      ST_CLEAR,
      ST_FINISH
   } lru_state_type;

   // controller to datapath commands
   typedef struct packed {
      logic load_req;
      logic rd_line;
      logic init_walk;
      logic issue_rd;
      logic clear_line;
      logic load_rsp;
   } lru_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic skip;
      logic is_victim;
      logic empty;
      logic no_walk;
      logic last;
      logic rsp_free;
   } lru_status_type;

endpackage

`default_nettype wire

// ===== sv/lru_ram.sv =====
// generic single write port, single read port ram with registered read
`default_nettype none

module lru_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== sv/lru_datapath.sv =====
// datapath: request and config registers, set bounds, age walk, victim search
`default_nettype none

module lru_datapath #(
   parameter int NUM_LINES = 64,
   parameter int AGE_BITS  = 7
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire lru_pkg::lru_req_type            req_data,
   input  wire logic                            csr_valid,
   input  wire logic [lru_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [lru_pkg::CSR_DATA_W-1:0]  csr_data,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output lru_pkg::lru_rsp_type                 rsp_data,
   input  wire lru_pkg::lru_cmd_type            cmd,
   output lru_pkg::lru_status_type              status
);

   localparam int LINE_W = $clog2(NUM_LINES);
   localparam int PW     = LINE_W + 1;
   localparam logic [13:0] NL14 = 14'(NUM_LINES);
   localparam logic [AGE_BITS-1:0] AGE_MAX = {AGE_BITS{1'b1}};

   // config registers
   logic       assoc_ff;
   logic [6:0] ways_ff;

   // request and walk registers
   lru_pkg::lru_req_type req_ff;
   logic [12:0]          base_ff;
   logic [AGE_BITS-1:0]  ref_ff;
   logic [PW-1:0]        ptr_ff;
   logic                 pend_ff;
   logic [LINE_W-1:0]    pend_addr_ff;
   logic [LINE_W-1:0]    best_ff;
   logic [AGE_BITS-1:0]  best_age_ff;
   logic                 done_ff;
   logic [NUM_LINES-1:0] vld_ff;
   logic                 vld_q_ff;
   logic                 rsp_valid_ff;
   lru_pkg::lru_rsp_type rsp_data_ff;

   // combinational signals
   logic [13:0]         lo_full, hi_full, lo_cl, hi_cl;
   logic [PW-1:0]       lo, hi, ptr_nx;
   logic [LINE_W-1:0]   line_addr, rd_addr, wr_addr;
   logic                rd_en, wr_en;
   logic [AGE_BITS-1:0] ram_q, rd_age, wr_data;
   logic                is_hf, is_victim, in_range, walk_wr;

   // request decode
   assign is_victim = (req_ff.req_type == lru_pkg::REQ_VICTIM);
   assign is_hf     = (req_ff.req_type == lru_pkg::REQ_HIT) ||
                      (req_ff.req_type == lru_pkg::REQ_FILL);
   assign in_range  = 32'(req_ff.line_index) < NUM_LINES;
   assign line_addr = LINE_W'(req_ff.line_index);

   // set bounds, clipped to the array
   always_comb begin
      lo_full = {1'b0, base_ff};
      hi_full = lo_full + 14'(ways_ff);
      lo_cl   = (lo_full > NL14) ? NL14 : lo_full;
      hi_cl   = (hi_full > NL14) ? NL14 : hi_full;
      lo      = assoc_ff ? PW'(lo_cl) : '0;
      hi      = assoc_ff ? PW'(hi_cl) : PW'(NUM_LINES);
   end

   assign ptr_nx = ptr_ff + PW'(1);

   // status to controller
   always_comb begin
      status.skip      = !(is_hf && in_range) && !is_victim;
      status.is_victim = is_victim;
      status.empty     = !(lo < hi);
      status.no_walk   = !req_ff.line_valid || !(lo < hi);
      status.last      = (ptr_nx == hi);
      status.rsp_free  = !rsp_valid_ff || rsp_ready;
   end

   // age of the entry read last cycle, unwritten entries read as zero
   assign rd_age = vld_q_ff ? ram_q : '0;

   // aging of one walked entry
   always_comb begin
      walk_wr = 1'b0;
      if (pend_ff && !is_victim) begin
         if (req_ff.req_type == lru_pkg::REQ_HIT) begin
            walk_wr = (rd_age < ref_ff);
         end else begin
            walk_wr = (rd_age != AGE_MAX);
         end
      end
   end

   // ram port muxing
   always_comb begin
      rd_en   = cmd.rd_line || cmd.issue_rd;
      rd_addr = cmd.rd_line ? line_addr : ptr_ff[LINE_W-1:0];
      wr_en   = cmd.clear_line || walk_wr;
      wr_addr = cmd.clear_line ? line_addr : pend_addr_ff;
      wr_data = cmd.clear_line ? '0 : rd_age + AGE_BITS'(1);
   end

   lru_ram #(
      .WIDTH(AGE_BITS),
      .DEPTH(NUM_LINES)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(ram_q)
   );

   // control state with reset
   always_ff @(posedge clock) begin
      if (reset) begin
         assoc_ff     <= lru_pkg::ASSOC_MODE_RESET;
         ways_ff      <= lru_pkg::SET_WAYS_RESET;
         vld_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_index == lru_pkg::CSR_ASSOC_MODE) begin
            assoc_ff <= csr_data[0];
         end
         if (csr_valid && csr_index == lru_pkg::CSR_SET_WAYS) begin
            ways_ff <= csr_data[6:0];
         end
         if (wr_en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
         pend_ff <= cmd.issue_rd;
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff <= req_data;
      end
      if (cmd.rd_line) begin
         base_ff <= 13'(req_ff.set_index) * 13'(ways_ff);
      end
      if (rd_en) begin
         vld_q_ff <= vld_ff[rd_addr];
      end
      if (cmd.init_walk) begin
         ref_ff      <= rd_age;
         ptr_ff      <= lo;
         best_ff     <= lo[LINE_W-1:0];
         best_age_ff <= '0;
         done_ff     <= !(status.skip || (is_victim && status.empty));
      end else begin
         if (cmd.issue_rd) begin
            ptr_ff <= ptr_nx;
         end
         if (pend_ff && is_victim && rd_age >= best_age_ff) begin
            best_ff     <= pend_addr_ff;
            best_age_ff <= rd_age;
         end
      end
      if (cmd.issue_rd) begin
         pend_addr_ff <= ptr_ff[LINE_W-1:0];
      end
      if (cmd.load_rsp) begin
         rsp_data_ff.victim_line <= (is_victim && done_ff) ? 6'(best_ff)
                                                           : req_ff.line_index;
         rsp_data_ff.done_res    <= done_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ===== sv/lru_controller.sv =====
// controller state machine sequencing one request through the datapath
`default_nettype none

module lru_controller (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire lru_pkg::lru_status_type status,
   output lru_pkg::lru_cmd_type        cmd
);

   lru_pkg::lru_state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lru_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         lru_pkg::ST_IDLE: begin
            req_ready    = 1'b1;
            cmd.load_req = req_valid;
            if (req_valid) begin
               state_in = lru_pkg::ST_BOUNDS;
            end
         end
         // base of the set and read of the accessed line
         lru_pkg::ST_BOUNDS: begin
            cmd.rd_line = 1'b1;
            state_in    = lru_pkg::ST_REF;
         end
         // capture reference age and set up the walk, or skip or shorten it
         lru_pkg::ST_REF: begin
            cmd.init_walk = 1'b1;
            if (status.skip || (status.is_victim && status.empty)) begin
               state_in = lru_pkg::ST_FINISH;
            end else if (!status.is_victim && status.no_walk) begin
               state_in = lru_pkg::ST_CLEAR;
            end else begin
               state_in = lru_pkg::ST_WALK;
            end
         end
         lru_pkg::ST_WALK: begin
            cmd.issue_rd = 1'b1;
            if (status.last) begin
               state_in = lru_pkg::ST_DRAIN;
            end
         end
         // last read in flight is processed here
         lru_pkg::ST_DRAIN: begin
            state_in = status.is_victim ? lru_pkg::ST_FINISH : lru_pkg::ST_CLEAR;
         end
         lru_pkg::ST_CLEAR: begin
            cmd.clear_line = 1'b1;
            state_in       = lru_pkg::ST_FINISH;
         end
         // hand the result to the output register once it is free
         lru_pkg::ST_FINISH: begin
            if (status.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = lru_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lru_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== sv/lru_age_counter_replacement.sv =====
// top level of the lru age counter replacement block
// usage:
//   request channel (req_valid/req_ready/req_data) takes one transaction at a
//   time: hit update, fill into a free line, or victim select.
//   response channel (rsp_valid/rsp_ready/rsp_data) returns one transaction per
//   request: the victim line or the echoed line index, and a done flag.
//   csr channel (csr_valid/csr_ready/csr_index/csr_data) writes assoc_mode
//   (index 0) and set_ways (index 1); it is always ready.
// walk:
//   a hit or fill that walks, and a victim select, read one age counter of
//   the set per cycle; a hit or fill writes it back when it ages. skipped
//   requests and victim selects on an empty set go straight to the result,
//   clear only requests clear the accessed line first. a new request is
//   taken in the cycle after the previous result is loaded.
// reset:
//   synchronous reset clears all ages through per-line valid bits at once,
//   sets assoc_mode to 1 and set_ways to 4; no clearing pass is needed.
// stalls:
//   the response sits in an output register; the next request is accepted
//   while it waits, and its own result is held until the register frees up.
`default_nettype none

module lru_age_counter_replacement #(
   parameter int NUM_LINES = 64,
   parameter int AGE_BITS  = 7
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire lru_pkg::lru_req_type            req_data,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output lru_pkg::lru_rsp_type                 rsp_data,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [lru_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [lru_pkg::CSR_DATA_W-1:0]  csr_data
);

   lru_pkg::lru_cmd_type    cmd;
   lru_pkg::lru_status_type status;

   // config writes are always taken
   assign csr_ready = 1'b1;

   lru_controller u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .status   (status),
      .cmd      (cmd)
   );

   lru_datapath #(
      .NUM_LINES(NUM_LINES),
      .AGE_BITS (AGE_BITS)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .csr_valid(csr_valid),
      .csr_index(csr_index),
      .csr_data (csr_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data),
      .cmd      (cmd),
      .status   (status)
   );

endmodule

`default_nettype wire

// ===== sv/lru_checker.sv =====
// port level checker for the lru age counter block, with its bind
`default_nettype none
`include "assert_macros.svh"

module lru_checker (
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 req_valid,
   input wire logic                 req_ready,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_ready,
   input wire lru_pkg::lru_rsp_type rsp_data
);

   // requests accepted whose response is not yet taken
   logic [1:0] outstanding_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         outstanding_ff <= 2'd0;
      end else begin
         outstanding_ff <= outstanding_ff + 2'(req_valid && req_ready)
                                          - 2'(rsp_valid && rsp_ready);
      end
   end

   // stalled response holds
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "response changed while stalled")
   // one request in work at a time
   `ASSERT_NEXT(a_one_in_work, clock, reset, req_valid && req_ready, !req_ready, "request accepted while another is in work")
   // no response without a request
   `ASSERT_IMPLIES(a_no_phantom, clock, reset, rsp_valid, outstanding_ff != 2'd0, "response without a pending request")
   // ready only with room for one more transaction
   `ASSERT_IMPLIES(a_bounded, clock, reset, req_ready, outstanding_ff == 2'd0 || outstanding_ff == 2'd1, "too many transactions outstanding")

endmodule

bind lru_age_counter_replacement lru_checker u_chk (.*);

`default_nettype wire

// ===== bench/lru_age_counter_replacement_tb.sv =====
// self-checking testbench for the lru age counter replacement block
`timescale 1ns / 1ps

module lru_age_counter_replacement_tb;

   localparam int LINES        = 64;
   localparam int AGE_W        = 7;
   localparam int QUIET_LIMIT  = 2000;
   localparam int SETTLE_COUNT = 100;
   localparam int REPORT_MAX   = 10;

   // the one request code the package leaves unnamed
   localparam logic [1:0] REQ_UNUSED = 2'd3;
   localparam logic [AGE_W-1:0] AGE_TOP = '1;

   logic                            clock     = 1'b0;
   logic                            reset     = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_ready;
   lru_pkg::lru_req_type            req_data  = '0;
   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   lru_pkg::lru_rsp_type            rsp_data;
   logic                            csr_valid = 1'b0;
   logic                            csr_ready;
   logic [lru_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [lru_pkg::CSR_DATA_W-1:0]  csr_data  = '0;

   // age counters and registers as the block should hold them
   logic [AGE_W-1:0] line_age [LINES];
   logic             cfg_assoc = lru_pkg::ASSOC_MODE_RESET;
   logic [6:0]       cfg_ways  = lru_pkg::SET_WAYS_RESET;

   lru_pkg::lru_req_type queued_req [$];
   lru_pkg::lru_rsp_type awaited_rsp [$];

   int  max_gap        = 3;
   int  max_stall      = 3;
   int  gap_left       = 0;
   int  stall_left     = 0;
   logic req_taken     = 1'b0;
   logic rsp_taken     = 1'b0;
   int  quiet_cycles   = 0;
   int  mismatch_count = 0;
   int  result_count   = 0;
   int  type_count [4] = '{0, 0, 0, 0};
   int  saturated_hits = 0;
   int  empty_victims  = 0;
   int  setting_count  = 1;

   lru_age_counter_replacement #(
      .NUM_LINES(LINES),
      .AGE_BITS (AGE_W)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // apply one request to the age counters, return the response it causes
   function automatic lru_pkg::lru_rsp_type apply_request(lru_pkg::lru_req_type r);
      int lo;
      int hi;
      int best;
      logic [AGE_W-1:0] pivot;
      lru_pkg::lru_rsp_type res;
      lo = 0;
      hi = LINES;
      if (cfg_assoc) begin
         lo = int'(r.set_index) * int'(cfg_ways);
         hi = lo + int'(cfg_ways);
         if (lo > LINES) lo = LINES;
         if (hi > LINES) hi = LINES;
      end
      res.victim_line = r.line_index;
      res.done_res    = 1'b0;
      case (r.req_type)
         lru_pkg::REQ_HIT, lru_pkg::REQ_FILL: begin
            if (int'(r.line_index) < LINES) begin
               // aging only when the accessed line is valid
               if (r.line_valid) begin
                  pivot = line_age[r.line_index];
                  for (int i = lo; i < hi; i++) begin
                     if (r.req_type == lru_pkg::REQ_HIT) begin
                        if (line_age[i] < pivot) line_age[i]++;
                     end else if (line_age[i] != AGE_TOP) begin
                        line_age[i]++;
                     end else begin
                        saturated_hits++;
                     end
                  end
               end
               line_age[r.line_index] = '0;
               res.done_res = 1'b1;
            end
         end
         lru_pkg::REQ_VICTIM: begin
            // oldest line wins, ties go to the higher index
            if (lo < hi) begin
               best = lo;
               for (int i = lo; i < hi; i++) begin
                  if (line_age[i] >= line_age[best]) best = i;
               end
               res.victim_line = best[5:0];
               res.done_res    = 1'b1;
            end else begin
               empty_victims++;
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   function automatic lru_pkg::lru_req_type make_req(logic [1:0] kind, int line, int set,
                                                     logic valid);
      lru_pkg::lru_req_type r;
      r.req_type   = kind;
      r.line_index = line[5:0];
      r.set_index  = set[5:0];
      r.line_valid = valid;
      return r;
   endfunction

   // random request; hot mode hammers a few lines so the others saturate
   function automatic lru_pkg::lru_req_type random_request(logic hot);
      lru_pkg::lru_req_type r;
      int pick;
      int ways;
      int set_sel;
      int line;
      pick = $urandom_range(0, 99);
      ways = int'(cfg_ways);
      r.set_index  = 6'($urandom_range(0, 63));
      r.line_index = 6'($urandom_range(0, 63));
      r.line_valid = ($urandom_range(0, 99) < 85);
      if (hot) begin
         r.set_index  = '0;
         r.line_index = 6'($urandom_range(0, 3));
         r.line_valid = ($urandom_range(0, 99) < 95);
         r.req_type   = (pick < 70) ? lru_pkg::REQ_FILL :
                        (pick < 85) ? lru_pkg::REQ_HIT : lru_pkg::REQ_VICTIM;
      end else begin
         r.req_type = (pick < 35) ? lru_pkg::REQ_HIT : (pick < 65) ? lru_pkg::REQ_FILL :
                      (pick < 95) ? lru_pkg::REQ_VICTIM : REQ_UNUSED;
         // mostly keep the line inside a set that exists
         if (cfg_assoc && ways >= 1 && ways <= LINES && $urandom_range(0, 99) < 80) begin
            set_sel = $urandom_range(0, (LINES - 1) / ways);
            line    = set_sel * ways + $urandom_range(0, ways - 1);
            if (line >= LINES) line = set_sel * ways;
            r.set_index  = set_sel[5:0];
            r.line_index = line[5:0];
         end
      end
      return r;
   endfunction

   // write both registers back to back while the block is idle
   task automatic configure(input logic assoc, input logic [6:0] ways);
      @(negedge clock);
      csr_index <= lru_pkg::CSR_ASSOC_MODE;
      csr_data  <= {6'b0, assoc};
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      cfg_assoc = assoc;
      @(negedge clock);
      csr_index <= lru_pkg::CSR_SET_WAYS;
      csr_data  <= ways;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      cfg_ways = ways;
      @(negedge clock);
      csr_valid <= 1'b0;
      setting_count++;
   endtask

   // sender holds off until every queued request has its response
   task automatic wait_idle();
      @(posedge clock);
      while (queued_req.size() != 0 || req_valid || awaited_rsp.size() != 0)
         @(posedge clock);
   endtask

   task automatic run_phase(input logic assoc, input logic [6:0] ways, input int gap,
                            input int stall, input logic hot, input int count);
      configure(assoc, ways);
      max_gap   = gap;
      max_stall = stall;
      for (int n = 0; n < count; n++) queued_req.push_back(random_request(hot));
      wait_idle();
   endtask

   // request driver, changes inputs on the falling edge
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else if (!req_valid || req_taken) begin
         if (req_taken) gap_left = $urandom_range(0, max_gap);
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (queued_req.size() != 0) begin
            req_data  <= queued_req.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // predict on every accepted request transaction
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
         for (int i = 0; i < LINES; i++) line_age[i] = '0;
      end else begin
         req_taken <= req_valid && req_ready;
         if (req_valid && req_ready) begin
            type_count[req_data.req_type]++;
            awaited_rsp.push_back(apply_request(req_data));
         end
      end
   end

   // response ready with random stalls
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_taken) stall_left = $urandom_range(0, max_stall);
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // response monitor, compares against the oldest prediction
   always @(posedge clock) begin
      lru_pkg::lru_rsp_type want;
      if (reset) begin
         rsp_taken <= 1'b0;
      end else begin
         rsp_taken <= rsp_valid && rsp_ready;
         if (rsp_valid && rsp_ready) begin
            result_count++;
            if (awaited_rsp.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_MAX)
                  $display("unexpected response: victim_line %0d done_res %0d",
                           rsp_data.victim_line, rsp_data.done_res);
            end else begin
               want = awaited_rsp.pop_front();
               if (rsp_data.victim_line !== want.victim_line ||
                   rsp_data.done_res !== want.done_res) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_MAX) begin
                     $display("mismatch on response %0d: expected victim_line %0d done_res %0d",
                              result_count, want.victim_line, want.done_res);
                     $display("   got victim_line %0d done_res %0d",
                              rsp_data.victim_line, rsp_data.done_res);
                  end
               end
            end
         end
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles", quiet_cycles);
         $display("FAILED: results differ");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed part under reset settings: four-way sets
      queued_req.push_back(make_req(lru_pkg::REQ_VICTIM, 0, 0, 1'b1));
      queued_req.push_back(make_req(lru_pkg::REQ_FILL, 0, 0, 1'b1));
      queued_req.push_back(make_req(lru_pkg::REQ_FILL, 1, 0, 1'b1));
      queued_req.push_back(make_req(lru_pkg::REQ_HIT, 2, 0, 1'b1));
      queued_req.push_back(make_req(lru_pkg::REQ_HIT, 3, 0, 1'b0));
      queued_req.push_back(make_req(lru_pkg::REQ_VICTIM, 0, 0, 1'b0));
      queued_req.push_back(make_req(lru_pkg::REQ_FILL, 63, 15, 1'b1));
      queued_req.push_back(make_req(lru_pkg::REQ_VICTIM, 7, 15, 1'b1));
      queued_req.push_back(make_req(lru_pkg::REQ_HIT, 60, 15, 1'b1));
      // line outside its own set
      queued_req.push_back(make_req(lru_pkg::REQ_HIT, 5, 0, 1'b1));
      queued_req.push_back(make_req(lru_pkg::REQ_FILL, 40, 0, 1'b1));
      // sets that fall past the array
      queued_req.push_back(make_req(lru_pkg::REQ_VICTIM, 9, 16, 1'b1));
      queued_req.push_back(make_req(lru_pkg::REQ_VICTIM, 63, 63, 1'b1));
      queued_req.push_back(make_req(lru_pkg::REQ_HIT, 63, 63, 1'b1));
      queued_req.push_back(make_req(lru_pkg::REQ_FILL, 0, 63, 1'b1));
      // unused request code
      queued_req.push_back(make_req(REQ_UNUSED, 63, 63, 1'b1));
      queued_req.push_back(make_req(REQ_UNUSED, 0, 0, 1'b0));
      queued_req.push_back(make_req(lru_pkg::REQ_FILL, 0, 0, 1'b0));
      queued_req.push_back(make_req(lru_pkg::REQ_VICTIM, 0, 0, 1'b1));
      queued_req.push_back(make_req(lru_pkg::REQ_VICTIM, 42, 1, 1'b0));
      wait_idle();

      // random part over several settings, extremes included
      run_phase(1'b0, 7'd4, 3, 3, 1'b0, 125);
      run_phase(1'b0, 7'd4, 0, 0, 1'b1, 200);
      run_phase(1'b1, 7'd1, 3, 3, 1'b0, 125);
      run_phase(1'b1, 7'd64, 3, 0, 1'b1, 150);
      run_phase(1'b1, 7'd0, 3, 3, 1'b0, 40);
      run_phase(1'b1, 7'd127, 0, 3, 1'b0, 60);
      run_phase(1'b1, 7'($urandom_range(2, 16)), 3, 3, 1'b0, 125);
      run_phase(1'b1, 7'd8, 3, 3, 1'b0, 125);
      run_phase(1'b1, 7'd4, 0, 0, 1'b0, 125);
      run_phase(1'b0, 7'd1, 3, 3, 1'b0, 150);

      // let any stray response show up
      repeat (SETTLE_COUNT) @(posedge clock);
      if (awaited_rsp.size() != 0)
         $display("%0d responses never arrived", awaited_rsp.size());
      $display("covered %0d hits, %0d fills, %0d victims, %0d unused codes, %0d settings",
               type_count[lru_pkg::REQ_HIT], type_count[lru_pkg::REQ_FILL],
               type_count[lru_pkg::REQ_VICTIM], type_count[REQ_UNUSED], setting_count);
      $display("%0d saturated ages held, %0d victim selects on empty sets, %0d mismatches",
               saturated_hits, empty_victims, mismatch_count);
      if (mismatch_count == 0 && awaited_rsp.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

// ===== lru_age_counter_replacement.f =====
+incdir+sv
sv/lru_pkg.sv
sv/lru_ram.sv
sv/lru_datapath.sv
sv/lru_controller.sv
sv/lru_age_counter_replacement.sv
sv/lru_checker.sv
bench/lru_age_counter_replacement_tb.sv
